// ===== hdl/keyboard_matrix_column_reader_assert.svh =====
// Assertion macros shared by the keyboard matrix column reader modules.
`ifndef KEYBOARD_MATRIX_COLUMN_READER_ASSERT_SVH
`define KEYBOARD_MATRIX_COLUMN_READER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KMCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmcr assertion failed");

// Next-cycle implication, checked outside reset
`define KMCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmcr assertion failed");

`endif

// ===== hdl/kmcr_pkg.sv =====
// Shared constants and types of the keyboard matrix column reader.
package kmcr_pkg;

    localparam int KEY_COUNT = 128;
    localparam int KEY_IDX_W = $clog2(KEY_COUNT);
    localparam int MASK_W    = 64;

    localparam logic [2:0] FN_LOAD       = 3'd0;
    localparam logic [2:0] FN_KEY        = 3'd1;
    localparam logic [2:0] FN_PORT_WRITE = 3'd2;
    localparam logic [2:0] FN_PB_OUT     = 3'd3;
    localparam logic [2:0] FN_PB_READ    = 3'd4;

    localparam logic [7:0] COLUMN_PORT   = 8'h08;
    localparam int         UPPER_BIT     = 4;

    // Decoded item held in the processing stage
    typedef struct packed {
        logic [2:0] func;
        logic       code_zero;
        logic [7:0] port_number;
        logic [7:0] write_value;
    } op_t;

endpackage

// ===== hdl/kmcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmcr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/kmcr_keymap.sv =====
// Key mask table: RAM storage plus per-entry valid bits that read as zero until loaded.
`include "keyboard_matrix_column_reader_assert.svh"

module kmcr_keymap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [kmcr_pkg::KEY_IDX_W-1:0] addr,
    input  logic [kmcr_pkg::MASK_W-1:0]    wr_data,
    output logic [kmcr_pkg::MASK_W-1:0]    rd_data
);

    logic [kmcr_pkg::KEY_COUNT-1:0] valid_reg;
    logic                           hit_reg;
    logic [kmcr_pkg::MASK_W-1:0]    ram_q;

    kmcr_ram #(
        .WIDTH (kmcr_pkg::MASK_W),
        .DEPTH (kmcr_pkg::KEY_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (ram_q)
    );

    // Mark entries as loaded; capture the hit alongside the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[addr];
            end
        end
    end

    // Unloaded entries read as the cleared value
    assign rd_data = hit_reg ? ram_q : '0;

    `KMCR_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, wr_en, valid_reg[$past(addr)])
    `KMCR_ASSERT_NEXT(a_miss_reads_zero, clk, rst_n, rd_en && !valid_reg[addr], rd_data == '0)

endmodule

// ===== hdl/kmcr_matrix.sv =====
// Matrix state (pending/active masks, column and nibble select) and line selection.
module kmcr_matrix (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  kmcr_pkg::op_t               op,
    input  logic [kmcr_pkg::MASK_W-1:0] table_data,
    input  logic                        narrow_mode,
    output logic [3:0]                  lines
);

    logic [kmcr_pkg::MASK_W-1:0] pending_reg;
    logic [kmcr_pkg::MASK_W-1:0] pending_next;
    logic [kmcr_pkg::MASK_W-1:0] active_reg;
    logic [kmcr_pkg::MASK_W-1:0] active_next;
    logic [2:0]                  column_reg;
    logic [2:0]                  column_next;
    logic                        upper_reg;
    logic                        upper_next;
    logic [3:0]                  nibble;

    // Decode the item's effect on the matrix state
    always_comb
    begin
        pending_next = pending_reg;
        active_next  = active_reg;
        column_next  = column_reg;
        upper_next   = upper_reg;
        unique case (op.func)
            kmcr_pkg::FN_KEY:
            begin
                pending_next = op.code_zero ? '0 : table_data;
            end
            kmcr_pkg::FN_PORT_WRITE:
            begin
                if (op.port_number == kmcr_pkg::COLUMN_PORT)
                begin
                    if (op.write_value == 8'd0)
                    begin
                        active_next = pending_reg;
                    end
                    column_next = op.write_value[2:0];
                end
            end
            kmcr_pkg::FN_PB_OUT:
            begin
                upper_next = op.write_value[kmcr_pkg::UPPER_BIT];
            end
            default:
            begin
            end
        endcase
    end

    // Advance state once per transfer through the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            active_reg  <= '0;
            column_reg  <= '0;
            upper_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            active_reg  <= active_next;
            column_reg  <= column_next;
            upper_reg   <= upper_next;
        end
    end

    // Pick the nibble of the selected column and invert it
    assign nibble = narrow_mode ? {1'b0, column_reg} : {column_reg, upper_reg};
    assign lines  = ~active_reg[{nibble, 2'b00} +: 4];

endmodule

// ===== hdl/keyboard_matrix_column_reader.sv =====
// Keyboard matrix column reader: input handshake, processing stage and result register.
// A port B read passes through the processing stage register and the result register before its key_lines show.
// Throughput: one item per cycle while in_stall is low; the keymap RAM's registered read sets the extra stage.
// Input stalls only when a read waits in the stage while the result register is stalled.
// Reset (rst_n low, asynchronous) clears the keymap valid bits, masks, selects and mode.
`include "keyboard_matrix_column_reader_assert.svh"

module keyboard_matrix_column_reader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  key_code,
    input  logic [63:0] key_mask,
    input  logic [7:0]  port_number,
    input  logic [7:0]  write_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  key_lines,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic                        in_fire;
    logic                        s1_valid_reg;
    kmcr_pkg::op_t               s1_op_reg;
    logic                        s1_is_read;
    logic                        s1_fire;
    logic                        out_valid_reg;
    logic [3:0]                  key_lines_reg;
    logic                        narrow_mode_reg;
    logic [kmcr_pkg::MASK_W-1:0] table_data;
    logic [3:0]                  lines;

    // Handshake control
    assign s1_is_read = s1_op_reg.func == kmcr_pkg::FN_PB_READ;
    assign in_stall   = s1_valid_reg && s1_is_read && out_valid_reg && out_stall;
    assign in_fire    = in_valid && !in_stall;
    assign s1_fire    = s1_valid_reg && !in_stall;
    assign cfg_ready  = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            narrow_mode_reg <= cfg_data;
        end
    end

    // Keymap table, written and read on the input transfer
    kmcr_keymap u_keymap (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_fire && func == kmcr_pkg::FN_LOAD),
        .rd_en   (in_fire && func == kmcr_pkg::FN_KEY),
        .addr    (key_code[kmcr_pkg::KEY_IDX_W-1:0]),
        .wr_data (key_mask),
        .rd_data (table_data)
    );

    // Processing stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg.func        <= func;
            s1_op_reg.code_zero   <= key_code == 8'd0;
            s1_op_reg.port_number <= port_number;
            s1_op_reg.write_value <= write_value;
        end
    end

    kmcr_matrix u_matrix (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_fire),
        .op          (s1_op_reg),
        .table_data  (table_data),
        .narrow_mode (narrow_mode_reg),
        .lines       (lines)
    );

    // Result register: load on a read transfer, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_is_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_read)
        begin
            key_lines_reg <= lines;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_lines = key_lines_reg;

    `KMCR_ASSERT_IMP(a_stall_needs_read, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg)
    `KMCR_ASSERT_IMP(a_other_never_blocks, clk, rst_n, s1_valid_reg && !s1_is_read, s1_fire)
    `KMCR_ASSERT_NEXT(a_read_gives_result, clk, rst_n, s1_fire && s1_is_read, out_valid_reg)

endmodule
